FILE: hdl/osm_pkg.sv
// shared types, codes and constants of the ofdm subcarrier mapper
// no dependencies; used by every module in hdl/
package osm_pkg;

  // defaults for the top level parameters
  localparam int unsigned DEF_SLOTS           = 64;
  localparam int unsigned DEF_POLARITY_LENGTH = 127;
  localparam int unsigned DEF_PILOT_SPACING   = 8;
  localparam int unsigned DEF_SAMPLE_WIDTH    = 16;

  // fixed field widths
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned SYM_W      = 7;
  localparam int unsigned LEVEL_W    = 15;
  localparam int unsigned PNUM_W     = 2;
  localparam int unsigned TUSER_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd16384;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd2;

  // pilot number (mod 4) that carries the minus sign of the base pattern
  localparam logic [PNUM_W-1:0] PNUM_NEG = 2'd3;

  typedef enum logic [1:0] {
    CLS_NULL  = 2'd0,
    CLS_DATA  = 2'd1,
    CLS_PILOT = 2'd2
  } slot_class_e;

  // shared slot unit result
  typedef struct packed {
    slot_class_e cls;
    logic        active;
  } slot_info_t;

  // 1 where the pilot polarity sequence is -1
  localparam int unsigned POLARITY_MAX = 127;
  localparam bit NEG_POLARITY [POLARITY_MAX] = '{
    0,0,0,0,1,1,1,0,1,1,1,1,0,0,1,0,
    1,1,0,0,1,0,0,1,0,0,0,0,0,0,1,0,
    0,0,1,0,0,1,1,0,0,0,1,0,1,1,1,0,
    1,0,1,1,0,1,1,0,0,0,0,0,1,1,0,0,
    1,1,0,1,0,1,0,0,1,1,1,0,0,1,1,1,
    1,0,1,1,0,1,0,0,0,0,1,0,1,0,1,0,
    1,1,1,1,1,0,1,0,0,1,0,1,0,0,0,1,
    1,0,1,1,1,0,0,0,1,1,1,1,1,1,1
  };

endpackage

FILE: hdl/osm_slot_class.sv
// shared slot classifier: one mask bit and the running rank give the slot class
// depends on osm_pkg
module osm_slot_class #(
  parameter int unsigned PILOT_SPACING = osm_pkg::DEF_PILOT_SPACING,
  parameter int unsigned RK_W          = $clog2(PILOT_SPACING)
) (
  input  logic                active_i,
  input  logic [RK_W-1:0]     rank_i,
  output osm_pkg::slot_info_t info_o,
  output logic [RK_W-1:0]     rank_o
);

  localparam logic [RK_W-1:0] RANK_TOP = RK_W'(PILOT_SPACING - 1);

  logic at_top;

  assign at_top = (rank_i == RANK_TOP);

  always_comb begin
    info_o.active = active_i;
    rank_o        = rank_i;
    if (!active_i) begin
      info_o.cls = osm_pkg::CLS_NULL;
    end else if (at_top) begin
      info_o.cls = osm_pkg::CLS_PILOT;
      rank_o     = '0;
    end else begin
      info_o.cls = osm_pkg::CLS_DATA;
      rank_o     = rank_i + 1'b1;
    end
  end

endmodule

FILE: hdl/osm_pilot_gen.sv
// pilot sample: saturated level with sign from base pattern and polarity sequence
// depends on osm_pkg
module osm_pilot_gen #(
  parameter int unsigned SAMPLE_WIDTH = osm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic [osm_pkg::LEVEL_W-1:0] level_i,
  input  logic [osm_pkg::PNUM_W-1:0]  pnum_i,
  input  logic [osm_pkg::SYM_W-1:0]   sym_i,
  output logic signed [SAMPLE_WIDTH-1:0] pilot_o
);

  localparam logic [31:0] SMAX = 32'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);

  logic [31:0]             level_ext;
  logic [31:0]             mag_ext;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic                    neg;

  assign level_ext = 32'(level_i);
  assign mag_ext   = (level_ext > SMAX) ? SMAX : level_ext;
  assign mag       = mag_ext[SAMPLE_WIDTH-1:0];
  assign neg       = (pnum_i == osm_pkg::PNUM_NEG) ^ osm_pkg::NEG_POLARITY[sym_i];
  assign pilot_o   = neg ? -mag : mag;

endmodule

FILE: hdl/ofdm_subcarrier_mapper.sv
// top level of the ofdm subcarrier mapper / demapper with its slot sequencer
// depends on osm_pkg, osm_slot_class, osm_pilot_gen
//
// The block walks a symbol one subcarrier slot per clock, unless the output
// stalls, through a single shared slot classifier steered by the allocation mask.
// In map mode an accepted word is first registered, then one word is emitted per
// slot: the nulls and pilots ahead of its data slot, the data slot itself and,
// after the last data slot of the symbol, the trailing nulls and pilots; no new
// word is taken until that run ends. Demap mode and the no-data error handle a
// word on acceptance. The pace is set by the one-slot-per-cycle walk and the
// single output register (one word per cycle out, unless stalled). A write of the
// mask starts a scan over the mask through the same classifier, which finds the
// last data slot; s_axis_tready stays low during the scan. Configuration writes
// are taken at any time; direction and mask writes restart the current symbol.
module ofdm_subcarrier_mapper #(
  parameter int unsigned SLOTS           = osm_pkg::DEF_SLOTS,
  parameter int unsigned POLARITY_LENGTH = osm_pkg::DEF_POLARITY_LENGTH,
  parameter int unsigned PILOT_SPACING   = osm_pkg::DEF_PILOT_SPACING,
  parameter int unsigned SAMPLE_WIDTH    = osm_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned IN_TDATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int unsigned OUT_TDATA_W     = ((2 * SAMPLE_WIDTH + osm_pkg::SLOT_W + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [osm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [osm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input samples
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_TDATA_W-1:0]           s_axis_tdata,   // in_real, in_imag
  // output samples
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_TDATA_W-1:0]          m_axis_tdata,   // out_real, out_imag, slot
  output logic [osm_pkg::TUSER_W-1:0]     m_axis_tuser,   // slot_class, symbol_end,
                                                          // no_data_error
  output logic                            m_axis_tlast    // run_last
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned RK_W  = $clog2(PILOT_SPACING);
  localparam int unsigned SW    = SAMPLE_WIDTH;

  localparam logic [IDX_W-1:0]          POS_LAST = IDX_W'(SLOTS - 1);
  localparam logic [osm_pkg::SYM_W-1:0] SYM_LAST = osm_pkg::SYM_W'(POLARITY_LENGTH - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_MAP   = 2'd2;

  // control and configuration state
  logic [1:0]                    state_q, state_d;
  logic [SLOTS-1:0]              mask_q, mask_d;
  logic                          dir_q, dir_d;
  logic [osm_pkg::LEVEL_W-1:0]   level_q, level_d;
  logic [IDX_W-1:0]              pos_q, pos_d;
  logic [RK_W-1:0]               rank_q, rank_d;
  logic [osm_pkg::PNUM_W-1:0]    pnum_q, pnum_d;
  logic [osm_pkg::SYM_W-1:0]     sym_q, sym_d;
  logic                          has_data_q, has_data_d;
  logic [IDX_W-1:0]              last_data_q, last_data_d;
  logic                          placed_q, placed_d;
  logic                          ov_q, ov_d;

  // payload
  logic signed [SW-1:0]          re_q, re_d, im_q, im_d;
  logic signed [SW-1:0]          o_re_q, o_re_d, o_im_q, o_im_d;
  logic [osm_pkg::SLOT_W-1:0]    o_slot_q, o_slot_d;
  osm_pkg::slot_class_e          o_cls_q, o_cls_d;
  logic                          o_end_q, o_end_d;
  logic                          o_last_q, o_last_d;
  logic                          o_err_q, o_err_d;

  logic                          out_free;
  logic                          s_accept;
  logic                          advance;
  logic                          placed_now;
  logic                          pos_end;
  logic signed [SW-1:0]          in_re, in_im;
  logic signed [SW-1:0]          pilot;
  osm_pkg::slot_info_t           info;
  logic [RK_W-1:0]               rank_nxt;

  // shared slot unit, fed by the slot pointer in every state
  osm_slot_class #(
    .PILOT_SPACING (PILOT_SPACING),
    .RK_W          (RK_W)
  ) u_slot_class (
    .active_i (mask_q[pos_q]),
    .rank_i   (rank_q),
    .info_o   (info),
    .rank_o   (rank_nxt)
  );

  osm_pilot_gen #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_pilot_gen (
    .level_i (level_q),
    .pnum_i  (pnum_q),
    .sym_i   (sym_q),
    .pilot_o (pilot)
  );

  assign in_re    = s_axis_tdata[SW-1:0];
  assign in_im    = s_axis_tdata[2*SW-1:SW];
  assign out_free = !ov_q || m_axis_tready;
  assign pos_end  = (pos_q == POS_LAST);

  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OUT_TDATA_W'({o_slot_q, o_im_q, o_re_q});
  assign m_axis_tuser  = {o_err_q, o_end_q, o_cls_q};
  assign m_axis_tlast  = o_last_q;

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    dir_d       = dir_q;
    level_d     = level_q;
    pos_d       = pos_q;
    rank_d      = rank_q;
    pnum_d      = pnum_q;
    sym_d       = sym_q;
    has_data_d  = has_data_q;
    last_data_d = last_data_q;
    placed_d    = placed_q;
    re_d        = re_q;
    im_d        = im_q;
    o_re_d      = o_re_q;
    o_im_d      = o_im_q;
    o_slot_d    = o_slot_q;
    o_cls_d     = o_cls_q;
    o_end_d     = o_end_q;
    o_last_d    = o_last_q;
    o_err_d     = o_err_q;
    ov_d        = m_axis_tready ? 1'b0 : ov_q;
    advance     = 1'b0;
    placed_now  = placed_q || (info.cls == osm_pkg::CLS_DATA);

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          if (!has_data_q) begin
            // no data slot in the mask: one error word, word dropped
            ov_d     = 1'b1;
            o_re_d   = '0;
            o_im_d   = '0;
            o_slot_d = '0;
            o_cls_d  = osm_pkg::CLS_NULL;
            o_end_d  = 1'b0;
            o_last_d = 1'b1;
            o_err_d  = 1'b1;
          end else if (dir_q) begin
            // demap: pass only data slots
            if (info.cls == osm_pkg::CLS_DATA) begin
              ov_d     = 1'b1;
              o_re_d   = in_re;
              o_im_d   = in_im;
              o_slot_d = osm_pkg::SLOT_W'(pos_q);
              o_cls_d  = osm_pkg::CLS_DATA;
              o_end_d  = pos_end;
              o_last_d = 1'b1;
              o_err_d  = 1'b0;
            end
            advance = 1'b1;
          end else begin
            re_d     = in_re;
            im_d     = in_im;
            placed_d = 1'b0;
            state_d  = S_MAP;
          end
        end
      end
      S_SWEEP: begin
        // mask scan: find whether and where the last data slot sits
        if (info.cls == osm_pkg::CLS_DATA) begin
          has_data_d  = 1'b1;
          last_data_d = pos_q;
        end
        rank_d = rank_nxt;
        if (pos_end) begin
          pos_d   = '0;
          rank_d  = '0;
          state_d = S_IDLE;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_MAP: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_slot_d = osm_pkg::SLOT_W'(pos_q);
          o_end_d  = pos_end;
          o_err_d  = 1'b0;
          if (info.cls == osm_pkg::CLS_DATA && !placed_q) begin
            o_re_d  = re_q;
            o_im_d  = im_q;
            o_cls_d = osm_pkg::CLS_DATA;
          end else if (info.cls == osm_pkg::CLS_PILOT) begin
            o_re_d  = pilot;
            o_im_d  = '0;
            o_cls_d = osm_pkg::CLS_PILOT;
          end else begin
            o_re_d  = '0;
            o_im_d  = '0;
            o_cls_d = info.cls;
          end
          // run ends at symbol end, or once placed with data still ahead
          o_last_d = pos_end || (placed_now && (last_data_q > pos_q));
          placed_d = placed_now;
          advance  = 1'b1;
          if (o_last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // step to the next slot, closing the symbol after the final slot
    if (advance) begin
      rank_d = rank_nxt;
      if (info.cls == osm_pkg::CLS_PILOT) begin
        pnum_d = pnum_q + 1'b1;
      end
      if (pos_end) begin
        pos_d  = '0;
        rank_d = '0;
        pnum_d = '0;
        sym_d  = (sym_q == SYM_LAST) ? '0 : sym_q + 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        osm_pkg::CFG_MASK: begin
          mask_d      = cfg_data_i[SLOTS-1:0];
          pos_d       = '0;
          rank_d      = '0;
          pnum_d      = '0;
          has_data_d  = 1'b0;
          last_data_d = '0;
          state_d     = S_SWEEP;
        end
        osm_pkg::CFG_DIR: begin
          dir_d = cfg_data_i[0];
          // the scan owns the slot pointer and clears it when done
          if (state_q != S_SWEEP) begin
            pos_d  = '0;
            rank_d = '0;
            pnum_d = '0;
          end
        end
        osm_pkg::CFG_LEVEL: begin
          level_d = cfg_data_i[osm_pkg::LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= '0;
      dir_q       <= 1'b0;
      level_q     <= osm_pkg::LEVEL_RESET;
      pos_q       <= '0;
      rank_q      <= '0;
      pnum_q      <= '0;
      sym_q       <= '0;
      has_data_q  <= 1'b0;
      last_data_q <= '0;
      placed_q    <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      dir_q       <= dir_d;
      level_q     <= level_d;
      pos_q       <= pos_d;
      rank_q      <= rank_d;
      pnum_q      <= pnum_d;
      sym_q       <= sym_d;
      has_data_q  <= has_data_d;
      last_data_q <= last_data_d;
      placed_q    <= placed_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q     <= re_d;
    im_q     <= im_d;
    o_re_q   <= o_re_d;
    o_im_q   <= o_im_d;
    o_slot_q <= o_slot_d;
    o_cls_q  <= o_cls_d;
    o_end_q  <= o_end_d;
    o_last_q <= o_last_d;
    o_err_q  <= o_err_d;
  end

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench of the ofdm subcarrier mapper / demapper
// depends on osm_pkg and ofdm_subcarrier_mapper, which needs osm_slot_class and osm_pilot_gen
module testbench;

  localparam int unsigned SLOTS           = osm_pkg::DEF_SLOTS;
  localparam int unsigned POLARITY_LENGTH = osm_pkg::DEF_POLARITY_LENGTH;
  localparam int unsigned PILOT_SPACING   = osm_pkg::DEF_PILOT_SPACING;
  localparam int unsigned SW              = osm_pkg::DEF_SAMPLE_WIDTH;
  localparam int unsigned CFG_W           = osm_pkg::CFG_DATA_W;
  localparam int unsigned IN_W            = ((2 * SW + 7) / 8) * 8;
  localparam int unsigned OUT_W           = ((2 * SW + osm_pkg::SLOT_W + 7) / 8) * 8;

  // largest positive sample value, pilots saturate to it
  localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};

  // index with no register behind it, writes there are dropped
  localparam logic [osm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic DIR_MAP   = 1'b0;
  localparam logic DIR_DEMAP = 1'b1;

  // settle time before a register write: covers the mask scan and the pipeline
  localparam int unsigned DRAIN_CYCLES = SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_WORDS = 126;
  localparam int unsigned SEG_WORDS    = 19;

  typedef struct packed {
    logic [SW-1:0]              re;
    logic [SW-1:0]              im;
    logic [osm_pkg::SLOT_W-1:0] slot;
    osm_pkg::slot_class_e       cls;
    logic                       sym_end;
    logic                       last;
    logic                       err;
  } sample_out_t;

  typedef enum logic [0:0] {
    ROW_CFG  = 1'b0,
    ROW_WORD = 1'b1
  } row_kind_e;

  // one line of the directed stimulus table
  typedef struct packed {
    row_kind_e                        kind;
    logic [osm_pkg::CFG_IDX_W-1:0]    idx;
    logic [CFG_W-1:0]                 value;
    logic [SW-1:0]                    re;
    logic [SW-1:0]                    im;
    logic                             typed;
    sample_out_t                      want;
  } plan_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [osm_pkg::CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]                 cfg_data_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [IN_W-1:0]                  s_axis_tdata;   // in_real, in_imag
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [OUT_W-1:0]                 m_axis_tdata;   // out_real, out_imag, slot
  logic [osm_pkg::TUSER_W-1:0]      m_axis_tuser;   // slot_class, symbol_end, no_data_error
  logic                             m_axis_tlast;   // run_last

  // the typed expectation travels with the word that is on the bus
  logic        row_typed;
  sample_out_t row_expect;

  // predictor copy of the registers and the symbol walk
  logic [CFG_W-1:0]              cfg_mask;
  logic                          cfg_dir;
  logic [osm_pkg::LEVEL_W-1:0]   pilot_level;
  logic [osm_pkg::SLOT_W-1:0]    slot_pos;
  logic [6:0]                    active_count;
  logic [2:0]                    pilots_passed;
  logic [osm_pkg::SYM_W-1:0]     polarity_idx;
  osm_pkg::slot_class_e          slot_map [SLOTS];

  sample_out_t fresh_outputs[$];     // words caused by the word just accepted
  sample_out_t pending_outputs[$];   // words still owed by the block
  plan_row_t   plan[$];

  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  ofdm_subcarrier_mapper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic sample_out_t make_result(logic [SW-1:0] re, logic [SW-1:0] im,
                                              logic [osm_pkg::SLOT_W-1:0] slot,
                                              osm_pkg::slot_class_e cls,
                                              logic sym_end, logic last, logic err);
    sample_out_t r;
    r.re      = re;
    r.im      = im;
    r.slot    = slot;
    r.cls     = cls;
    r.sym_end = sym_end;
    r.last    = last;
    r.err     = err;
    return r;
  endfunction

  // every PILOT_SPACING-th active slot is a pilot, the other active ones carry data
  task automatic build_slot_map(output int n_data);
    int rank;
    rank   = 0;
    n_data = 0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_map[s] = osm_pkg::CLS_NULL;
      if (cfg_mask[s]) begin
        rank++;
        if (rank % PILOT_SPACING == 0) begin
          slot_map[s] = osm_pkg::CLS_PILOT;
        end else begin
          slot_map[s] = osm_pkg::CLS_DATA;
          n_data++;
        end
      end
    end
  endtask

  function automatic logic data_ahead();
    for (int s = slot_pos; s < SLOTS; s++) begin
      if (slot_map[s] == osm_pkg::CLS_DATA) return 1'b1;
    end
    return 1'b0;
  endfunction

  // sign: base pattern minus on every fourth pilot, flipped by the symbol polarity
  function automatic logic [SW-1:0] pilot_sample();
    logic [SW-1:0] mag;
    logic          neg;
    mag = {{(SW-osm_pkg::LEVEL_W){1'b0}}, pilot_level};
    if (mag > SAMPLE_MAX) mag = SAMPLE_MAX;
    neg = (pilots_passed[osm_pkg::PNUM_W-1:0] == osm_pkg::PNUM_NEG) ^
          osm_pkg::NEG_POLARITY[polarity_idx];
    return neg ? -mag : mag;
  endfunction

  task automatic restart_symbol();
    slot_pos      = '0;
    active_count  = '0;
    pilots_passed = '0;
  endtask

  task automatic step_slot(osm_pkg::slot_class_e c);
    if (c != osm_pkg::CLS_NULL) active_count = active_count + 1'b1;
    if (c == osm_pkg::CLS_PILOT) pilots_passed = pilots_passed + 1'b1;
    if (slot_pos == SLOTS - 1) begin
      restart_symbol();
      polarity_idx = (polarity_idx == POLARITY_LENGTH - 1) ? '0 : polarity_idx + 1'b1;
    end else begin
      slot_pos = slot_pos + 1'b1;
    end
  endtask

  task automatic apply_config(logic [osm_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      osm_pkg::CFG_MASK: begin
        cfg_mask = value;
        restart_symbol();
      end
      osm_pkg::CFG_DIR: begin
        cfg_dir = value[0];
        restart_symbol();
      end
      osm_pkg::CFG_LEVEL: pilot_level = value[osm_pkg::LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // fills fresh_outputs with the words that one accepted sample causes
  task automatic predict_emission(logic [SW-1:0] re, logic [SW-1:0] im);
    int                          n_data;
    logic [osm_pkg::SLOT_W-1:0]  pos;
    osm_pkg::slot_class_e        c;
    logic                        placed;
    logic                        at_end;
    sample_out_t                 tail;
    fresh_outputs.delete();
    build_slot_map(n_data);
    if (n_data == 0) begin
      // no data slot anywhere: one error word, sample dropped, state kept
      fresh_outputs.push_back(make_result('0, '0, '0, osm_pkg::CLS_NULL,
                                          1'b0, 1'b1, 1'b1));
    end else if (cfg_dir == DIR_DEMAP) begin
      pos = slot_pos;
      c   = slot_map[pos];
      if (c == osm_pkg::CLS_DATA) begin
        fresh_outputs.push_back(make_result(re, im, pos, osm_pkg::CLS_DATA,
                                            pos == SLOTS - 1, 1'b0, 1'b0));
      end
      step_slot(c);
    end else begin
      placed = 1'b0;
      forever begin
        pos    = slot_pos;
        c      = slot_map[pos];
        at_end = (pos == SLOTS - 1);
        if (c == osm_pkg::CLS_DATA && !placed) begin
          fresh_outputs.push_back(make_result(re, im, pos, osm_pkg::CLS_DATA,
                                              at_end, 1'b0, 1'b0));
          placed = 1'b1;
        end else if (c == osm_pkg::CLS_PILOT) begin
          fresh_outputs.push_back(make_result(pilot_sample(), '0, pos, osm_pkg::CLS_PILOT,
                                              at_end, 1'b0, 1'b0));
        end else begin
          fresh_outputs.push_back(make_result('0, '0, pos, c, at_end, 1'b0, 1'b0));
        end
        step_slot(c);
        if (at_end || fresh_outputs.size() >= SLOTS) break;
        // after the last data slot the trailing nulls and pilots close the symbol
        if (placed && data_ahead()) break;
      end
    end
    if (fresh_outputs.size() > 0) begin
      tail = fresh_outputs.pop_back();
      tail.last = 1'b1;
      fresh_outputs.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking: outputs against the oldest expectation, then prediction of inputs
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_and_predict
    sample_out_t got;
    sample_out_t want;
    cycle_count++;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = make_result(m_axis_tdata[SW-1:0], m_axis_tdata[2*SW-1:SW],
                          m_axis_tdata[2*SW+osm_pkg::SLOT_W-1:2*SW],
                          osm_pkg::slot_class_e'(m_axis_tuser[1:0]), m_axis_tuser[2],
                          m_axis_tlast, m_axis_tuser[3]);
        if (pending_outputs.size() == 0) begin
          $error("output word with nothing expected: slot %0d class %0d",
                 got.slot, got.cls);
          mismatches++;
        end else begin
          want = pending_outputs.pop_front();
          check_field("out_real", $signed(want.re), $signed(got.re));
          check_field("out_imag", $signed(want.im), $signed(got.im));
          check_field("slot", want.slot, got.slot);
          check_field("slot_class", want.cls, got.cls);
          check_field("symbol_end", want.sym_end, got.sym_end);
          check_field("run_last", want.last, got.last);
          check_field("no_data_error", want.err, got.err);
        end
      end
      if (cfg_we_i) apply_config(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        predict_emission(s_axis_tdata[SW-1:0], s_axis_tdata[2*SW-1:SW]);
        // table rows with a typed answer replace the predicted one
        if (row_typed) begin
          pending_outputs.push_back(row_expect);
        end else begin
          foreach (fresh_outputs[i]) pending_outputs.push_back(fresh_outputs[i]);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver side: random stalls, changed on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic plan_row_t row_cfg(logic [osm_pkg::CFG_IDX_W-1:0] idx,
                                        logic [CFG_W-1:0] value);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t row_word(logic [SW-1:0] re, logic [SW-1:0] im);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_WORD;
    r.re   = re;
    r.im   = im;
    return r;
  endfunction

  function automatic plan_row_t row_checked(logic [SW-1:0] re, logic [SW-1:0] im,
                                            sample_out_t want);
    plan_row_t r;
    r       = row_word(re, im);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // mostly random samples, now and then a corner value
  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return SW'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_mask();
    logic [CFG_W-1:0] m;
    case ($urandom_range(5))
      0: m = '1;
      1: begin
        // a few active slots: long runs of nulls per word
        m = '0;
        repeat ($urandom_range(4, 1)) m[$urandom_range(SLOTS - 1)] = 1'b1;
      end
      2: begin
        m = '1;
        repeat ($urandom_range(4, 1)) m[$urandom_range(SLOTS - 1)] = 1'b0;
      end
      3: m = {$urandom, $urandom} & {$urandom, $urandom};
      4: m = ($urandom_range(3) == 0) ? '0 : {$urandom, $urandom};
      default: m = {$urandom, $urandom};
    endcase
    return m;
  endfunction

  function automatic logic [CFG_W-1:0] pick_level();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 64'h7FFF;
      default: return CFG_W'($urandom_range(32767));
    endcase
  endfunction

  task automatic set_idling(int unsigned phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  // called just after a falling edge; returns just after the falling edge
  // that follows acceptance, with tvalid still high
  task automatic send_word(logic [SW-1:0] re, logic [SW-1:0] im,
                           logic typed, sample_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    row_typed     <= typed;
    row_expect    <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // hold the sender off until every expected word is out, then wait a bit more
  task automatic settle(int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_outputs.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // the write enable is dropped on the next falling edge, and the task waits once more
  // before it returns, so that back-to-back writes never touch it twice in one step
  task automatic write_reg(logic [osm_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    plan_row_t   row;
    sample_out_t no_data;
    int unsigned seg;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    row_typed     = 1'b0;
    row_expect    = '0;
    mismatches    = 0;
    words_sent    = 0;
    cycle_count   = 0;
    cfg_mask      = '0;
    cfg_dir       = DIR_MAP;
    pilot_level   = osm_pkg::LEVEL_RESET;
    slot_pos      = '0;
    active_count  = '0;
    pilots_passed = '0;
    polarity_idx  = '0;
    set_idling(3);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    no_data = make_result('0, '0, '0, osm_pkg::CLS_NULL, 1'b0, 1'b1, 1'b1);

    // directed table
    // empty mask after reset: every word gives the no-data error
    plan.push_back(row_checked(16'h7FFF, 16'h8000, no_data));
    plan.push_back(row_checked(16'h8000, 16'h7FFF, no_data));
    plan.push_back(row_cfg(CFG_UNUSED, '1));
    plan.push_back(row_cfg(osm_pkg::CFG_DIR, CFG_W'(DIR_DEMAP)));
    plan.push_back(row_checked(16'h1234, 16'hEDCB, no_data));
    plan.push_back(row_cfg(osm_pkg::CFG_DIR, CFG_W'(DIR_MAP)));
    // full mask: the first word lands in slot 0 alone
    plan.push_back(row_cfg(osm_pkg::CFG_MASK, '1));
    plan.push_back(row_checked(16'h7FFF, 16'h8000,
                               make_result(16'h7FFF, 16'h8000, '0, osm_pkg::CLS_DATA,
                                           1'b0, 1'b1, 1'b0)));
    plan.push_back(row_word(16'h8000, 16'h7FFF));
    // only the top slot active: one word spills a whole symbol of 64 words
    plan.push_back(row_cfg(osm_pkg::CFG_MASK, 64'h8000_0000_0000_0000));
    plan.push_back(row_word(16'h0001, 16'hFFFF));
    // nine active slots, eighth one a pilot at full level
    plan.push_back(row_cfg(osm_pkg::CFG_LEVEL, 64'h7FFF));
    plan.push_back(row_cfg(osm_pkg::CFG_MASK, 64'h1FF));
    repeat (8) plan.push_back(row_word(pick_sample(), pick_sample()));
    // demap the same layout: pilot and nulls are dropped
    plan.push_back(row_cfg(osm_pkg::CFG_LEVEL, '0));
    plan.push_back(row_cfg(osm_pkg::CFG_DIR, CFG_W'(DIR_DEMAP)));
    repeat (10) plan.push_back(row_word(pick_sample(), pick_sample()));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        settle(DRAIN_CYCLES);
        write_reg(row.idx, row.value);
      end else begin
        send_word(row.re, row.im, row.typed, row.want);
      end
    end

    // random part: segments with fresh settings and a different idling mix
    words_sent = 0;
    seg        = 0;
    while (words_sent < RANDOM_WORDS) begin
      set_idling(seg % 4);
      settle(DRAIN_CYCLES);
      if (seg == 0 || $urandom_range(1)) write_reg(osm_pkg::CFG_MASK, pick_mask());
      if (seg == 0 || $urandom_range(1)) begin
        // map mode most of the time, it walks the whole slot sequence
        write_reg(osm_pkg::CFG_DIR,
                  CFG_W'(($urandom_range(3) == 0) ? DIR_DEMAP : DIR_MAP));
      end
      if (seg == 0 || $urandom_range(1)) write_reg(osm_pkg::CFG_LEVEL, pick_level());
      for (int k = 0; k < SEG_WORDS; k++) begin
        // one pause with the sender held off until the output side is empty
        if (seg == 2 && k == SEG_WORDS / 2) settle(1);
        send_word(pick_sample(), pick_sample(), 1'b0, '0);
      end
      seg++;
    end

    settle(DRAIN_CYCLES);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: ofdm_subcarrier_mapper.f
hdl/osm_pkg.sv
hdl/osm_slot_class.sv
hdl/osm_pilot_gen.sv
hdl/ofdm_subcarrier_mapper.sv
tb/sv/testbench.sv
